// ===== src/base64_encoder_custom_alphabet_macros.svh =====
// Assertion macros used by the encoder top level.
`ifndef BASE64_ENCODER_CUSTOM_ALPHABET_MACROS_SVH
`define BASE64_ENCODER_CUSTOM_ALPHABET_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a condition at every rising clock edge outside reset.
`define B64E_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define B64E_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies another in the next cycle.
`define B64E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define B64E_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define B64E_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define B64E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/b64e_pkg.sv =====
// Types and constants of the base64 encoder.
package b64e_pkg;

  localparam int unsigned NUM_WORDS   = 8;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CHARS_PER_W = 8;
  localparam logic [7:0]  PAD_CHAR    = 8'h3D;
  localparam logic [1:0]  LAST_SLOT   = 2'd3;
  localparam logic [1:0]  FULL_COUNT  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_word_t;

  // One character slot of a group: a 6-bit alphabet index or a pad sign.
  typedef struct packed {
    logic       pad;
    logic [5:0] idx;
  } code_t;

endpackage

// ===== src/base64_encoder_custom_alphabet.sv =====
// Streaming base64 encoder with a loadable alphabet: top level.
//
// One byte enters per word; a byte that completes a group of three, or that
// ends the message, produces four characters that leave one per cycle on the
// result port while it is not stalled, with the last character of the message
// flagged. Bytes that only fill a group are taken in every cycle even while the
// previous group drains; the sustained rate is set by the single character
// result port. A group-closing byte waits until the group register hands over
// its fourth character. The closing byte's codes are loaded into the group
// register when it is accepted, and each character then passes through the
// output register. The alphabet lives in eight 64-bit configuration words
// written through the cfg port, which is always ready.
module base64_encoder_custom_alphabet (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  b64e_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output b64e_pkg::out_word_t             out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [b64e_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [b64e_pkg::CFG_DATA_W-1:0] cfg_data
);
  import b64e_pkg::*;
  `include "base64_encoder_custom_alphabet_macros.svh"

  // Held bytes of the open group.
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [7:0] held0_r, held1_r;

  // Group register: four character slots waiting to go out.
  logic       grp_valid_r, grp_valid_nxt;
  logic [1:0] grp_cnt_r, grp_cnt_nxt;
  logic       grp_last_r;
  code_t      grp_codes_r [4];
  code_t      codes_nxt [4];

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  logic       in_acc, emit, grp_done, out_load;
  logic [7:0] b;
  logic       fin;
  code_t      cur_code;
  logic [7:0] alpha_char;

  assign cfg_ready = 1'b1;

  b64e_alphabet u_alphabet (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .rd_idx   (cur_code.idx),
    .rd_char  (alpha_char)
  );

  assign b    = in_word.data_byte;
  assign fin  = in_word.final_byte;
  assign emit = (held_cnt_r == FULL_COUNT) || fin;

  assign out_load = grp_valid_r && (!out_valid_r || !out_stall);
  assign grp_done = out_load && (grp_cnt_r == LAST_SLOT);
  // Only a byte that produces characters needs the group register.
  assign in_stall = emit && grp_valid_r && !grp_done;
  assign in_acc   = in_valid && !in_stall;

  assign cur_code = grp_codes_r[grp_cnt_r];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      codes_nxt[i] = '0;
    end
    case (held_cnt_r)
      2'd0: begin
        codes_nxt[0] = '{pad: 1'b0, idx: b[7:2]};
        codes_nxt[1] = '{pad: 1'b0, idx: {b[1:0], 4'b0000}};
        codes_nxt[2] = '{pad: 1'b1, idx: 6'd0};
        codes_nxt[3] = '{pad: 1'b1, idx: 6'd0};
      end
      2'd1: begin
        codes_nxt[0] = '{pad: 1'b0, idx: held0_r[7:2]};
        codes_nxt[1] = '{pad: 1'b0, idx: {held0_r[1:0], b[7:4]}};
        codes_nxt[2] = '{pad: 1'b0, idx: {b[3:0], 2'b00}};
        codes_nxt[3] = '{pad: 1'b1, idx: 6'd0};
      end
      default: begin
        codes_nxt[0] = '{pad: 1'b0, idx: held0_r[7:2]};
        codes_nxt[1] = '{pad: 1'b0, idx: {held0_r[1:0], held1_r[7:4]}};
        codes_nxt[2] = '{pad: 1'b0, idx: {held1_r[3:0], b[7:6]}};
        codes_nxt[3] = '{pad: 1'b0, idx: b[5:0]};
      end
    endcase
  end

  always_comb begin
    held_cnt_nxt  = held_cnt_r;
    grp_valid_nxt = grp_valid_r;
    grp_cnt_nxt   = grp_cnt_r;
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      held_cnt_nxt = emit ? 2'd0 : held_cnt_r + 2'd1;
    end
    if (out_load) begin
      grp_cnt_nxt = grp_cnt_r + 2'd1;
    end
    if (grp_done) begin
      grp_valid_nxt = 1'b0;
    end
    if (in_acc && emit) begin
      grp_valid_nxt = 1'b1;
      grp_cnt_nxt   = 2'd0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r  <= 2'd0;
      grp_valid_r <= 1'b0;
      grp_cnt_r   <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      held_cnt_r  <= held_cnt_nxt;
      grp_valid_r <= grp_valid_nxt;
      grp_cnt_r   <= grp_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !emit) begin
      if (held_cnt_r == 2'd0) begin
        held0_r <= b;
      end else begin
        held1_r <= b;
      end
    end
    if (in_acc && emit) begin
      for (int i = 0; i < 4; i++) begin
        grp_codes_r[i] <= codes_nxt[i];
      end
      grp_last_r <= fin;
    end
    if (out_load) begin
      out_word_r.out_char  <= cur_code.pad ? PAD_CHAR : alpha_char;
      out_word_r.last_char <= grp_last_r && (grp_cnt_r == LAST_SLOT);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `B64E_ASSERT_ALWAYS(a_held_cnt_range, clk, rst_n, held_cnt_r != 2'd3, "held count reached three")
  `B64E_ASSERT_IMPLIES(a_stall_needs_group, clk, rst_n, in_stall, grp_valid_r && emit, "stall without a busy group")
  `B64E_ASSERT_IMPLIES(a_no_early_pad, clk, rst_n, grp_valid_r && !grp_cnt_r[1], !cur_code.pad, "pad sign in first two slots")
  `B64E_ASSERT_NEXT(a_done_clears, clk, rst_n, grp_done && !(in_acc && emit), !grp_valid_r, "group still valid after last slot")

endmodule

// ===== src/b64e_alphabet.sv =====
// Loadable 64-character alphabet with one combinational read port.
module b64e_alphabet (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [b64e_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [b64e_pkg::CFG_DATA_W-1:0] wr_data,
  input  logic [5:0]                      rd_idx,
  output logic [7:0]                      rd_char
);
  import b64e_pkg::*;

  logic [CFG_DATA_W-1:0] words_r [NUM_WORDS];
  logic [CFG_DATA_W-1:0] sel_word;
  logic                  idx_in_range;

  // Indexes past the last word are dropped.
  assign idx_in_range = (wr_index[CFG_IDX_W-1:3] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_r[i] <= '0;
      end
    end else if (wr_en && idx_in_range) begin
      words_r[wr_index[2:0]] <= wr_data;
    end
  end

  always_comb begin
    sel_word = words_r[rd_idx[5:3]];
    rd_char  = sel_word[{rd_idx[2:0], 3'b000} +: 8];
  end

endmodule

// ===== verif/base64_encoder_custom_alphabet_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the streaming base64 encoder with a loadable alphabet.
module base64_encoder_custom_alphabet_tb;
  import b64e_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_SHOWN     = 10;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  in_word_t    byte_q[$];
  out_word_t   expected_chars[$];
  logic [63:0] alpha_word [NUM_WORDS];
  logic [63:0] next_alpha [NUM_WORDS];
  logic [7:0]  held_byte [2];
  logic [1:0]  held_n;
  int unsigned in_idle;
  int unsigned out_hold;
  bit          in_quiet;
  bit          out_quiet;
  int unsigned mismatches;
  string       std_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  base64_encoder_custom_alphabet u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none at all in a quiet stretch.
  function automatic int unsigned draw_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] alpha_char(input logic [5:0] idx);
    return alpha_word[idx[5:3]][{idx[2:0], 3'b000} +: 8];
  endfunction

  // Works out the characters that one accepted byte releases.
  task automatic encode_byte(input in_word_t w);
    logic [7:0] b;
    logic [7:0] b0;
    logic [7:0] b1;
    b  = w.data_byte;
    b0 = held_byte[0];
    b1 = held_byte[1];
    if (held_n >= FULL_COUNT) begin
      expected_chars.push_back({alpha_char(b0[7:2]), 1'b0});
      expected_chars.push_back({alpha_char({b0[1:0], b1[7:4]}), 1'b0});
      expected_chars.push_back({alpha_char({b1[3:0], b[7:6]}), 1'b0});
      expected_chars.push_back({alpha_char(b[5:0]), w.final_byte});
      held_n = '0;
    end else if (!w.final_byte) begin
      held_byte[held_n[0]] = b;
      held_n = held_n + 2'd1;
    end else if (held_n == 2'd0) begin
      expected_chars.push_back({alpha_char(b[7:2]), 1'b0});
      expected_chars.push_back({alpha_char({b[1:0], 4'b0000}), 1'b0});
      expected_chars.push_back({PAD_CHAR, 1'b0});
      expected_chars.push_back({PAD_CHAR, 1'b1});
      held_n = '0;
    end else begin
      expected_chars.push_back({alpha_char(b0[7:2]), 1'b0});
      expected_chars.push_back({alpha_char({b0[1:0], b[7:4]}), 1'b0});
      expected_chars.push_back({alpha_char({b[3:0], 2'b00}), 1'b0});
      expected_chars.push_back({PAD_CHAR, 1'b1});
      held_n = '0;
    end
  endtask

  // Input side: a word stays put while stalled, the next one comes after a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_idle = 0;
    end else begin
      if (in_valid && !in_stall) encode_byte(in_word);
      if (!in_valid || !in_stall) begin
        if (in_idle > 0) begin
          in_idle = in_idle - 1;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          in_valid <= 1'b1;
          in_word  <= byte_q.pop_front();
          in_idle = draw_gap(in_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: compare each accepted word with the oldest expectation, and drive random stalls.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: unexpected character %h last %b", $realtime,
                     out_word.out_char, out_word.last_char);
        end else begin
          if (out_word.out_char !== expected_chars[0].out_char ||
              out_word.last_char !== expected_chars[0].last_char) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_SHOWN)
              $display("%0t: expected char %h last %b, got char %h last %b", $realtime,
                       expected_chars[0].out_char, expected_chars[0].last_char,
                       out_word.out_char, out_word.last_char);
          end
          void'(expected_chars.pop_front());
        end
      end
      if (out_hold > 0) begin
        out_hold = out_hold - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_hold = draw_gap(out_quiet);
      end
    end
  end

  // Called right after a rising edge; leaves cfg_valid high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_WORDS) alpha_word[idx[2:0]] = val;
  endtask

  task automatic write_alphabet();
    for (int i = 0; i < NUM_WORDS; i++) write_reg(i[CFG_IDX_W-1:0], next_alpha[i]);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_byte(input logic [7:0] b, input logic fin);
    in_word_t w;
    w.data_byte  = b;
    w.final_byte = fin;
    byte_q.push_back(w);
  endtask

  // Whole messages of random length, so every group and every padding case recurs.
  task automatic queue_messages(input int unsigned n_items);
    int unsigned done_n;
    int unsigned len;
    int unsigned r;
    logic [7:0]  b;
    done_n = 0;
    while (done_n < n_items) begin
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(1, 6);
      else if (r < 95) len = $urandom_range(7, 15);
      else len = $urandom_range(16, 40);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) b = $urandom_range(1) ? 8'hFF : 8'h00;
        else b = 8'($urandom_range(255));
        add_byte(b, i == len - 1);
      end
      done_n = done_n + len;
    end
  endtask

  // Returns right after a rising edge once the block has gone quiet.
  task automatic wait_idle();
    do @(posedge clk); while (byte_q.size() != 0 || in_valid || expected_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_idling();
    in_quiet  = ($urandom_range(3) == 0);
    out_quiet = ($urandom_range(3) == 0);
  endtask

  initial begin
    foreach (alpha_word[i]) alpha_word[i] = '0;
    held_byte[0] = '0;
    held_byte[1] = '0;
    held_n       = '0;
    mismatches   = 0;
    in_quiet     = 1'b0;
    out_quiet    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Standard alphabet, then the boundary bytes and every way a message can end.
    for (int i = 0; i < 64; i++) next_alpha[i / 8][(i % 8) * 8 +: 8] = std_alphabet[i];
    write_alphabet();
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b0); add_byte(8'h00, 1'b1);
    add_byte(8'h00, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hAA, 1'b1);
    add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);
    add_byte(8'h55, 1'b1);
    add_byte(8'h12, 1'b0); add_byte(8'h34, 1'b0); add_byte(8'h56, 1'b0);
    add_byte(8'h78, 1'b0); add_byte(8'h9A, 1'b1);
    add_byte(8'hFC, 1'b0); add_byte(8'h03, 1'b0); add_byte(8'hF0, 1'b0);
    add_byte(8'h0F, 1'b0); add_byte(8'hC3, 1'b0); add_byte(8'h3C, 1'b1);
    wait_idle();

    // Character k equals k, so any slip in the index shows up directly.
    for (int i = 0; i < 64; i++) next_alpha[i / 8][(i % 8) * 8 +: 8] = 8'(i);
    write_alphabet();
    pick_idling();
    queue_messages(50);
    wait_idle();

    // Writes past the last alphabet word, which the block drops; the whole alphabet is then rewritten.
    write_reg(4'd15, '1);
    write_reg(4'd8 + 4'($urandom_range(7)), {$urandom, $urandom});
    foreach (next_alpha[i]) next_alpha[i] = '1;
    write_alphabet();
    in_quiet  = 1'b1;
    out_quiet = 1'b1;
    queue_messages(20);
    wait_idle();

    foreach (next_alpha[i]) next_alpha[i] = '0;
    write_alphabet();
    pick_idling();
    queue_messages(20);
    wait_idle();

    // Random alphabet, repeats and unprintable entries included.
    foreach (next_alpha[i]) next_alpha[i] = {$urandom, $urandom};
    write_alphabet();
    pick_idling();
    queue_messages(50);
    wait_idle();

    for (int i = 0; i < 64; i++) next_alpha[i / 8][(i % 8) * 8 +: 8] = std_alphabet[i];
    write_alphabet();
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
    queue_messages(40);
    wait_idle();

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("base64_encoder_custom_alphabet_tb: clean");
    end else begin
      if (expected_chars.size() != 0)
        $display("%0d expected characters never arrived", expected_chars.size());
      $display("base64_encoder_custom_alphabet_tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: block stopped making progress");
    $display("base64_encoder_custom_alphabet_tb: errors");
    $finish;
  end

endmodule
